/* hw/rtl/sfqd_pkg.sv */
`default_nettype none
package sfqd_pkg;
   localparam int NumFlowsDefault   = 2;
   localparam int QueueDepthDefault = 64;
   localparam int TagW    = 31;
   localparam int HandleW = 16;
   localparam int LenW    = 31;
   localparam int WtW     = 8;
   localparam int LvlW    = 32;
   localparam int DepthW  = 8;
   localparam logic [TagW-1:0] TagMax = {TagW{1'b1}};
   localparam logic [DepthW-1:0] DepthLimitReset = 8'd8;
   localparam logic [TagW-1:0] OveruseThreshReset = 31'd10240;

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_DIFF     = 2'd2,
      OP_NEW_IO   = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_DEPTH_LIMIT = 1'b0,
      CSR_OVERUSE_THR = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_PICK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic            start;
      logic [LenW-1:0] dividend;
      logic [WtW-1:0]  divisor;
   } div_req_type;
endpackage
`default_nettype wire

/* hw/rtl/sfqd_divider.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module sfqd_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfqd_pkg::div_req_type req,
   output logic                       busy,
   output logic [sfqd_pkg::LenW-1:0]  quotient
);
   localparam int LenW = sfqd_pkg::LenW;
   localparam int WtW  = sfqd_pkg::WtW;
   localparam int CntW = $clog2(LenW + 1);

   logic [LenW-1:0] quot_ff, quot_in;
   logic [WtW:0]    rem_ff, rem_in;
   logic [WtW-1:0]  dvs_ff, dvs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [WtW:0]    trial;
   logic [WtW:0]    shifted;

   // Shift one dividend bit into the remainder and try a subtract
   always_comb begin
      shifted = {rem_ff[WtW-1:0], quot_ff[LenW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         dvs_in  = (req.divisor == '0) ? WtW'(1) : req.divisor;
         cnt_in  = CntW'(LenW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WtW]) begin
            rem_in  = trial;
            quot_in = {quot_ff[LenW-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[LenW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

/* hw/rtl/sfqd_queue_mem.sv */
`default_nettype none
// Request store: one write port, one registered read port.
module sfqd_queue_mem #(
   parameter int NUM_FLOWS   = sfqd_pkg::NumFlowsDefault,
   parameter int QUEUE_DEPTH = sfqd_pkg::QueueDepthDefault
) (
   input  wire logic                                            clock,
   input  wire logic                                            wr_en,
   input  wire logic [$clog2(NUM_FLOWS*QUEUE_DEPTH)-1:0]        wr_addr,
   input  wire logic [sfqd_pkg::HandleW+sfqd_pkg::TagW-1:0]     wr_data,
   input  wire logic [$clog2(NUM_FLOWS*QUEUE_DEPTH)-1:0]        rd_addr,
   output logic      [sfqd_pkg::HandleW+sfqd_pkg::TagW-1:0]     rd_data
);
   localparam int Entries = NUM_FLOWS * QUEUE_DEPTH;
   localparam int DataW   = sfqd_pkg::HandleW + sfqd_pkg::TagW;

   logic [DataW-1:0] mem_ff [Entries];
   logic [DataW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

/* hw/rtl/sfq_depth_fair_dispatch_core.sv */
`default_nettype none
// Enqueue: the divide state waits for the 31-step divider, then the output state sends the result word.
// Complete and new_io: a read and a pick state per flow, in flow order,
// through the single memory read port; a level update reads only its own flow.
// One word in work at a time; a new word is taken once the result is out.
// Synchronous active-high reset clears all per-flow state; the queue
// memory itself is not cleared and its entries are only used below the fill count.
module sfq_depth_fair_dispatch_core #(
   parameter int NUM_FLOWS   = sfqd_pkg::NumFlowsDefault,
   parameter int QUEUE_DEPTH = sfqd_pkg::QueueDepthDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic                          req_flow,
   input  wire logic [sfqd_pkg::HandleW-1:0]  req_request_handle,
   input  wire logic [sfqd_pkg::LenW-1:0]     req_length,
   input  wire logic [sfqd_pkg::WtW-1:0]      req_weight,
   input  wire logic signed [sfqd_pkg::LvlW-1:0] req_overuse_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_dispatched,
   output logic                               rsp_out_flow,
   output logic [sfqd_pkg::HandleW-1:0]       rsp_out_handle,
   output logic [sfqd_pkg::TagW-1:0]          rsp_out_start_tag,
   output logic                               rsp_dispatch_hint,
   output logic                               rsp_queue_full,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_index,
   input  wire logic [31:0]                   csr_wdata
);
   localparam int TagW  = sfqd_pkg::TagW;
   localparam int HW    = sfqd_pkg::HandleW;
   localparam int DW    = sfqd_pkg::DepthW;
   localparam int LvlW  = sfqd_pkg::LvlW;
   localparam int FW    = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
   localparam int PW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int AW    = $clog2(NUM_FLOWS * QUEUE_DEPTH);
   localparam int SW    = FW + 1;

   // Per-flow state
   logic [CW-1:0]   cnt_ff  [NUM_FLOWS];
   logic [PW-1:0]   head_ff [NUM_FLOWS];
   logic [TagW-1:0] vt_ff   [NUM_FLOWS];
   logic [TagW-1:0] lf_ff   [NUM_FLOWS];
   logic [DW-1:0]   inf_ff  [NUM_FLOWS];
   logic signed [LvlW-1:0] ovr_ff [NUM_FLOWS];
   logic [DW-1:0]   dlim_ff;
   logic [TagW-1:0] thr_ff;

   // Latched word
   sfqd_pkg::state_type state_ff, state_in;
   sfqd_pkg::op_type op_ff;
   logic [FW-1:0] flow_ff;
   logic [HW-1:0] handle_ff;
   logic [TagW-1:0] stag_ff;
   logic [SW-1:0] scan_ff;
   logic          found_ff;
   logic [FW-1:0] best_ff;
   logic [TagW-1:0] best_tag_ff;
   logic [HW-1:0] best_h_ff;

   // Result register
   logic          rv_ff;
   logic          r_disp_ff, r_flow_ff, r_hint_ff, r_full_ff;
   logic [HW-1:0] r_handle_ff;
   logic [TagW-1:0] r_tag_ff;

   logic req_acc;
   logic div_busy;
   logic [sfqd_pkg::LenW-1:0] quotient;
   sfqd_pkg::div_req_type div_req;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [HW+TagW-1:0] mem_wdata, mem_rdata;
   logic [FW-1:0] cur_flow;
   logic [FW-1:0] rd_flow;
   logic          cand_ok;
   logic [TagW:0] fin_sum;
   logic [PW:0]   pos_sum;
   logic [PW-1:0] pos;
   logic [FW-1:0] in_flow;
   logic          in_flow_ok;

   assign in_flow_ok = ({{(32-1){1'b0}}, req_flow} < 32'(NUM_FLOWS));
   assign in_flow    = FW'(req_flow);
   // Hold the input while busy or while a result word waits on the output
   assign req_stall  = (state_ff != sfqd_pkg::ST_IDLE) || (rv_ff && rsp_stall);
   assign req_acc    = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   sfqd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign div_req.start    = req_acc && in_flow_ok &&
                             (req_operation == sfqd_pkg::OP_ENQUEUE);
   assign div_req.dividend = req_length;
   assign div_req.divisor  = req_weight;

   sfqd_queue_mem #(.NUM_FLOWS(NUM_FLOWS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Scan order: a level update reads only its own flow
   assign cur_flow = (op_ff == sfqd_pkg::OP_DIFF) ? flow_ff : scan_ff[FW-1:0];
   assign mem_raddr = AW'(cur_flow) * AW'(QUEUE_DEPTH) + AW'(head_ff[cur_flow]);
   assign rd_flow  = best_ff;

   // Append position and finish tag for enqueue; drop the write on a full queue
   assign pos_sum  = {1'b0, head_ff[flow_ff]} + (PW+1)'(cnt_ff[flow_ff]);
   assign pos      = (pos_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                     PW'(pos_sum - (PW+1)'(QUEUE_DEPTH)) : pos_sum[PW-1:0];
   assign fin_sum  = {1'b0, stag_ff} + {1'b0, quotient};
   assign mem_we   = (state_ff == sfqd_pkg::ST_DIV) && !div_busy &&
                     (cnt_ff[flow_ff] < CW'(QUEUE_DEPTH));
   assign mem_waddr = AW'(flow_ff) * AW'(QUEUE_DEPTH) + AW'(pos);
   assign mem_wdata = {handle_ff, stag_ff};

   // Candidate for the flow just read
   always_comb begin
      cand_ok = (cnt_ff[cur_flow] != '0) && (inf_ff[cur_flow] < dlim_ff);
      if (op_ff != sfqd_pkg::OP_DIFF) begin
         cand_ok = cand_ok && !(ovr_ff[cur_flow] > $signed({1'b0, thr_ff}));
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfqd_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (!in_flow_ok) state_in = sfqd_pkg::ST_OUT;
               else if (req_operation == sfqd_pkg::OP_ENQUEUE) begin
                  state_in = sfqd_pkg::ST_DIV;
               end else state_in = sfqd_pkg::ST_READ;
            end
         end
         sfqd_pkg::ST_DIV:  if (!div_busy) state_in = sfqd_pkg::ST_OUT;
         sfqd_pkg::ST_READ: state_in = sfqd_pkg::ST_PICK;
         sfqd_pkg::ST_PICK: begin
            if (op_ff == sfqd_pkg::OP_DIFF ||
                scan_ff == SW'(NUM_FLOWS - 1)) state_in = sfqd_pkg::ST_OUT;
            else state_in = sfqd_pkg::ST_READ;
         end
         sfqd_pkg::ST_OUT:  if (!rv_ff || !rsp_stall) state_in = sfqd_pkg::ST_IDLE;
         default: state_in = sfqd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfqd_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
         dlim_ff  <= sfqd_pkg::DepthLimitReset;
         thr_ff   <= sfqd_pkg::OveruseThreshReset;
         found_ff <= 1'b0;
         for (int i = 0; i < NUM_FLOWS; i++) begin
            cnt_ff[i]  <= '0;
            head_ff[i] <= '0;
            vt_ff[i]   <= '0;
            lf_ff[i]   <= '0;
            inf_ff[i]  <= '0;
            ovr_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         // Register writes
         if (csr_valid) begin
            if (csr_index == sfqd_pkg::CSR_DEPTH_LIMIT) dlim_ff <= csr_wdata[DW-1:0];
            else thr_ff <= csr_wdata[TagW-1:0];
         end
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;

         unique case (state_ff)
            sfqd_pkg::ST_IDLE: begin
               if (req_acc) begin
                  op_ff      <= sfqd_pkg::op_type'(req_operation);
                  flow_ff    <= in_flow;
                  handle_ff  <= req_request_handle;
                  stag_ff    <= (vt_ff[in_flow] > lf_ff[in_flow]) ?
                                vt_ff[in_flow] : lf_ff[in_flow];
                  scan_ff    <= '0;
                  found_ff   <= 1'b0;
                  r_disp_ff  <= 1'b0;
                  r_flow_ff  <= 1'b0;
                  r_handle_ff <= '0;
                  r_tag_ff   <= '0;
                  r_hint_ff  <= 1'b0;
                  r_full_ff  <= 1'b0;
                  if (in_flow_ok) begin
                     if (req_operation == sfqd_pkg::OP_COMPLETE &&
                         inf_ff[in_flow] != '0) begin
                        inf_ff[in_flow] <= inf_ff[in_flow] - DW'(1);
                     end
                     if (req_operation == sfqd_pkg::OP_DIFF) begin
                        ovr_ff[in_flow] <= req_overuse_level;
                     end
                  end
               end
            end
            sfqd_pkg::ST_DIV: begin
               // Commit enqueue once the quotient is ready
               if (!div_busy) begin
                  if (cnt_ff[flow_ff] >= CW'(QUEUE_DEPTH)) begin
                     r_full_ff <= 1'b1;
                  end else begin
                     lf_ff[flow_ff] <= fin_sum[TagW] ? sfqd_pkg::TagMax
                                                     : fin_sum[TagW-1:0];
                     r_hint_ff <= !(ovr_ff[flow_ff] > $signed({1'b0, thr_ff})) &&
                                  (inf_ff[flow_ff] < dlim_ff) &&
                                  (cnt_ff[flow_ff] == '0);
                     cnt_ff[flow_ff] <= cnt_ff[flow_ff] + CW'(1);
                  end
               end
            end
            sfqd_pkg::ST_READ: ;
            sfqd_pkg::ST_PICK: begin
               // Keep the smallest head tag, lowest flow on a tie
               if (cand_ok && (!found_ff || mem_rdata[TagW-1:0] < best_tag_ff)) begin
                  found_ff    <= 1'b1;
                  best_ff     <= cur_flow;
                  best_tag_ff <= mem_rdata[TagW-1:0];
                  best_h_ff   <= mem_rdata[HW+TagW-1:TagW];
               end
               scan_ff <= scan_ff + SW'(1);
            end
            sfqd_pkg::ST_OUT: begin
               if (!rv_ff || !rsp_stall) begin
                  rv_ff <= 1'b1;
                  if (found_ff) begin
                     r_disp_ff   <= 1'b1;
                     r_flow_ff   <= rd_flow[0];
                     r_handle_ff <= best_h_ff;
                     r_tag_ff    <= best_tag_ff;
                     vt_ff[rd_flow]  <= best_tag_ff;
                     inf_ff[rd_flow] <= inf_ff[rd_flow] + DW'(1);
                     head_ff[rd_flow] <= (head_ff[rd_flow] == PW'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_ff[rd_flow] + PW'(1);
                     cnt_ff[rd_flow] <= cnt_ff[rd_flow] - CW'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_dispatched    = r_disp_ff;
   assign rsp_out_flow      = r_flow_ff;
   assign rsp_out_handle    = r_handle_ff;
   assign rsp_out_start_tag = r_tag_ff;
   assign rsp_dispatch_hint = r_hint_ff;
   assign rsp_queue_full    = r_full_ff;
endmodule
`default_nettype wire
